FILE: rtl/core/error_diffusion_dither_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the error diffusion dither
// Concurrent checks on clk_i. With SYNTHESIS defined they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_TOP_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check that is switched off while rst_ni is low.
`define EDD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("edd: assertion failed");
// Check that also holds while reset is applied.
`define EDD_ASSERT_ARST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("edd: assertion failed");
`else
`define EDD_ASSERT(lbl, prop)
`define EDD_ASSERT_ARST(lbl, prop)
`endif

`endif

FILE: rtl/core/edd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither package
// Widths, register codes, payload types and fixed point helpers.
// ----------------------------------------------------------------------------
package edd_pkg;

  // image and number format
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned FRAC_BITS  = 4;
  localparam int unsigned STORE_BITS = FRAC_BITS + 10;
  localparam int unsigned ACC_BITS   = STORE_BITS + 2;
  localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_BITS   = 8;
  localparam int unsigned LW_BITS    = 13;
  localparam int unsigned THR_BITS   = 12;
  localparam int unsigned THR_SHIFT  = FRAC_BITS - 4;
  localparam int unsigned CMP_BITS   = (LW_BITS > COL_BITS + 1) ? LW_BITS : COL_BITS + 1;

  // diffusion weights, in sixteenths
  localparam int unsigned SHARE_SHIFT = 4;
  localparam logic [2:0]  W_RIGHT      = 3'd7;
  localparam logic [2:0]  W_BELOW_LEFT = 3'd3;
  localparam logic [2:0]  W_BELOW      = 3'd5;
  localparam logic [2:0]  W_BELOW_RGT  = 3'd1;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = LW_BITS;

  localparam logic [LW_BITS-1:0]  LINE_WIDTH_RST = LW_BITS'(4096);
  localparam logic [THR_BITS-1:0] THRESHOLD_RST  = THR_BITS'(2040);
  localparam logic [PIX_BITS-1:0] TOP_VALUE_RST  = PIX_BITS'(255);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_THRESHOLD  = 2'd1,
    CFG_TOP_VALUE  = 2'd2
  } cfg_idx_e;

  // result buffer
  localparam int unsigned OUT_DEPTH    = 4;
  localparam int unsigned OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  typedef logic signed [STORE_BITS-1:0] err_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_in;
    logic                frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_out;
    logic                row_end;
  } out_t;

  localparam acc_t SAT_HI = ACC_BITS'((1 << (STORE_BITS - 1)) - 1);
  localparam acc_t SAT_LO = ACC_BITS'(-(1 << (STORE_BITS - 1)));

  // clamp a wide sum to the stored error range
  function automatic err_t sat_store(input acc_t v);
    err_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[STORE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[STORE_BITS-1:0];
    end else begin
      r = v[STORE_BITS-1:0];
    end
    return r;
  endfunction

  // floor(k * e / 16)
  function automatic err_t share_of(input err_t e, input logic [2:0] k);
    logic signed [STORE_BITS+2:0] p;
    p = (STORE_BITS + 3)'(e) * $signed({1'b0, k});
    return STORE_BITS'(p >>> SHARE_SHIFT);
  endfunction

endpackage

FILE: rtl/core/error_diffusion_dither_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither, top level
// Floyd-Steinberg dither of a raster stream of 8-bit samples, one line of
// diffused errors held in a RAM.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  in        input      in_valid_i / in_stall_o  in_data_i  (pixel_in, frame_start)
//  out       output     out_valid_o / out_stall_i out_data_o (pixel_out, row_end)
//  cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
//  One request per clock while in_stall_o is low: the compute stage closes the
//  right-hand carry loop. Results go from the compute stage to the buffer.
//  A row end past column 0 writes two line RAM entries on one port: the row end entry
//  is held and goes out next cycle, or is held in turn behind a one-pixel row.
//  The input stalls once the four-entry result buffer and the compute stage
//  hold four results. Reset: no clearing pass; RAM data is ignored on the first row.
// ----------------------------------------------------------------------------
`include "error_diffusion_dither_top_macros.svh"

module error_diffusion_dither_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  edd_pkg::in_t                          in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output edd_pkg::out_t                         out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [edd_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [edd_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  localparam int unsigned COL_BITS     = edd_pkg::COL_BITS;
  localparam int unsigned CMP_BITS     = edd_pkg::CMP_BITS;
  localparam int unsigned ACC_BITS     = edd_pkg::ACC_BITS;
  localparam int unsigned PIX_BITS     = edd_pkg::PIX_BITS;
  localparam int unsigned OUT_PTR_BITS = edd_pkg::OUT_PTR_BITS;
  localparam int unsigned OUT_CNT_BITS = edd_pkg::OUT_CNT_BITS;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [edd_pkg::LW_BITS-1:0]  line_width_q, line_width_d;
  logic [edd_pkg::THR_BITS-1:0] threshold_q, threshold_d;
  logic [PIX_BITS-1:0]          top_value_q, top_value_d;

  always_comb begin
    line_width_d = line_width_q;
    threshold_d  = threshold_q;
    top_value_d  = top_value_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        edd_pkg::CFG_LINE_WIDTH: line_width_d = cfg_data_i[edd_pkg::LW_BITS-1:0];
        edd_pkg::CFG_THRESHOLD:  threshold_d  = cfg_data_i[edd_pkg::THR_BITS-1:0];
        edd_pkg::CFG_TOP_VALUE:  top_value_d  = cfg_data_i[PIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= edd_pkg::LINE_WIDTH_RST;
      threshold_q  <= edd_pkg::THRESHOLD_RST;
      top_value_q  <= edd_pkg::TOP_VALUE_RST;
    end else begin
      line_width_q <= line_width_d;
      threshold_q  <= threshold_d;
      top_value_q  <= top_value_d;
    end
  end

  // --------------------------------------------------------------------------
  // front: column tracking and line RAM read
  // --------------------------------------------------------------------------
  logic                in_accept;
  logic [CMP_BITS-1:0] width_eff;
  logic [COL_BITS-1:0] col_q, col_d;
  logic                first_row_q, first_row_d;
  logic [COL_BITS-1:0] s0_col;
  logic                s0_first;
  logic                s0_last;

  assign in_accept = in_valid_i & ~in_stall_o;

  always_comb begin
    if (line_width_q == '0) begin
      width_eff = CMP_BITS'(1);
    end else if (CMP_BITS'(line_width_q) > CMP_BITS'(edd_pkg::MAX_WIDTH)) begin
      width_eff = CMP_BITS'(edd_pkg::MAX_WIDTH);
    end else begin
      width_eff = CMP_BITS'(line_width_q);
    end
  end

  assign s0_col   = in_data_i.frame_start ? '0 : col_q;
  assign s0_first = in_data_i.frame_start | first_row_q;
  assign s0_last  = (CMP_BITS'(s0_col) + CMP_BITS'(1)) >= width_eff;

  always_comb begin
    col_d       = col_q;
    first_row_d = first_row_q;
    if (in_accept) begin
      if (s0_last) begin
        col_d       = '0;
        first_row_d = 1'b0;
      end else begin
        col_d       = s0_col + COL_BITS'(1);
        first_row_d = s0_first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
    end else begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
    end
  end

  // --------------------------------------------------------------------------
  // compute stage
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  logic [PIX_BITS-1:0] s1_pix_q;
  logic [COL_BITS-1:0] s1_col_q;
  logic                s1_last_q;
  logic                s1_first_q;
  logic                s1_fs_q;

  edd_pkg::err_t rc_q, rc_d;
  edd_pkg::err_t bp0_q, bp0_d;
  edd_pkg::err_t bp1_q, bp1_d;
  logic          byp_hit_q, byp_hit_d;
  edd_pkg::err_t byp_data_q, byp_data_d;

  edd_pkg::err_t ram_rdata;
  edd_pkg::err_t mem_val;
  edd_pkg::err_t rc_eff, bp0_eff, bp1_eff;
  edd_pkg::acc_t pix_fx, rc_ext, mem_ext, acc_sum, acc_ext, thr_fx, out_fx;
  edd_pkg::err_t acc;
  edd_pkg::err_t err;
  edd_pkg::err_t s7, s3, s5, s1;
  logic          hit;
  logic [PIX_BITS-1:0] out_level;
  edd_pkg::err_t wa_data, wb_data;
  logic          wa_en, wb_en;

  assign mem_val = byp_hit_q ? byp_data_q : ram_rdata;
  assign rc_eff  = s1_fs_q ? '0 : rc_q;
  assign bp0_eff = s1_fs_q ? '0 : bp0_q;
  assign bp1_eff = s1_fs_q ? '0 : bp1_q;

  assign pix_fx  = $signed(ACC_BITS'(s1_pix_q) << edd_pkg::FRAC_BITS);
  assign rc_ext  = ACC_BITS'(rc_eff);
  assign mem_ext = s1_first_q ? '0 : ACC_BITS'(mem_val);
  assign acc_sum = pix_fx + rc_ext + mem_ext;
  assign acc     = edd_pkg::sat_store(acc_sum);
  assign acc_ext = ACC_BITS'(acc);

  assign thr_fx    = $signed(ACC_BITS'(threshold_q) << edd_pkg::THR_SHIFT);
  assign hit       = acc_ext >= thr_fx;
  assign out_level = hit ? top_value_q : '0;
  assign out_fx    = $signed(ACC_BITS'(out_level) << edd_pkg::FRAC_BITS);
  assign err       = edd_pkg::sat_store(acc_ext - out_fx);

  assign s7 = edd_pkg::share_of(err, edd_pkg::W_RIGHT);
  assign s3 = edd_pkg::share_of(err, edd_pkg::W_BELOW_LEFT);
  assign s5 = edd_pkg::share_of(err, edd_pkg::W_BELOW);
  assign s1 = edd_pkg::share_of(err, edd_pkg::W_BELOW_RGT);

  // below-left share completes the column to the left; at a row end the
  // column itself is complete too
  assign wa_data = edd_pkg::sat_store(ACC_BITS'(bp0_eff) + ACC_BITS'(s3));
  assign wb_data = edd_pkg::sat_store(ACC_BITS'(bp1_eff) + ACC_BITS'(s5));
  assign wa_en   = s1_valid_q & (s1_col_q != '0);
  assign wb_en   = s1_valid_q & s1_last_q;

  always_comb begin
    rc_d  = rc_q;
    bp0_d = bp0_q;
    bp1_d = bp1_q;
    if (s1_valid_q) begin
      if (s1_last_q) begin
        rc_d  = '0;
        bp0_d = '0;
        bp1_d = '0;
      end else begin
        rc_d  = s7;
        bp0_d = wb_data;
        bp1_d = s1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rc_q       <= '0;
      bp0_q      <= '0;
      bp1_q      <= '0;
      byp_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      rc_q       <= rc_d;
      bp0_q      <= bp0_d;
      bp1_q      <= bp1_d;
      byp_hit_q  <= byp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q   <= in_data_i.pixel_in;
      s1_col_q   <= s0_col;
      s1_last_q  <= s0_last;
      s1_first_q <= s0_first;
      s1_fs_q    <= in_data_i.frame_start;
    end
    byp_data_q <= byp_data_d;
  end

  // --------------------------------------------------------------------------
  // line RAM write port, held row-end write and read forwarding
  // --------------------------------------------------------------------------
  logic                pend_q, pend_d;
  logic [COL_BITS-1:0] pend_addr_q;
  edd_pkg::err_t       pend_data_q;
  logic                ram_we;
  logic [COL_BITS-1:0] ram_waddr;
  edd_pkg::err_t       ram_wdata;

  // row end with another write due this cycle: send that one, hold the row end
  assign pend_d = wb_en & (wa_en | pend_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_col_q;
    ram_wdata = wb_data;
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = pend_data_q;
    end else if (wa_en) begin
      ram_we    = 1'b1;
      ram_waddr = s1_col_q - COL_BITS'(1);
      ram_wdata = wa_data;
    end else if (wb_en) begin
      ram_we = 1'b1;
    end
  end

  // the RAM returns old data on a clash; take the newer value instead
  always_comb begin
    byp_hit_d  = byp_hit_q;
    byp_data_d = byp_data_q;
    if (in_accept) begin
      byp_hit_d = 1'b0;
      if (pend_d && (s1_col_q == s0_col)) begin
        byp_hit_d  = 1'b1;
        byp_data_d = wb_data;
      end else if (ram_we && (ram_waddr == s0_col)) begin
        byp_hit_d  = 1'b1;
        byp_data_d = ram_wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_d) begin
      pend_addr_q <= s1_col_q;
      pend_data_q <= wb_data;
    end
  end

  edd_ram #(
    .WIDTH (edd_pkg::STORE_BITS),
    .DEPTH (edd_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (s0_col),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // result buffer
  // --------------------------------------------------------------------------
  edd_pkg::out_t                 fifo_q [edd_pkg::OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0]       wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_BITS-1:0]       out_cnt_q, out_cnt_d;
  logic [OUT_CNT_BITS:0]         occupancy;
  logic                          push, pop;
  edd_pkg::out_t                 result;

  assign result.pixel_out = out_level;
  assign result.row_end   = s1_last_q;

  assign push = s1_valid_q;
  assign pop  = out_valid_o & ~out_stall_i;

  // count the item in the compute stage too: it lands in the buffer next
  assign occupancy  = (OUT_CNT_BITS + 1)'(out_cnt_q) + (OUT_CNT_BITS + 1)'(s1_valid_q);
  assign in_stall_o = occupancy >= (OUT_CNT_BITS + 1)'(edd_pkg::OUT_DEPTH);

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (push && !pop) begin
      out_cnt_d = out_cnt_q + OUT_CNT_BITS'(1);
    end else if (pop && !push) begin
      out_cnt_d = out_cnt_q - OUT_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_BITS'(1);
      end
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= result;
    end
  end

  assign out_valid_o = out_cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `EDD_ASSERT(a_pend_drains, (pend_q && !wb_en) |=> !pend_q)
  `EDD_ASSERT(a_pend_no_clash, pend_q |-> !wa_en)
  `EDD_ASSERT(a_row_wraps, (s1_valid_q && s1_last_q) |=> (!s1_valid_q || s1_col_q == '0))
  `EDD_ASSERT(a_result_queued, s1_valid_q |=> out_valid_o)
  `EDD_ASSERT_ARST(a_buffer_bound, out_cnt_q <= OUT_CNT_BITS'(edd_pkg::OUT_DEPTH))

endmodule

FILE: rtl/core/edd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module edd_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned ABITS = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ABITS-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [ABITS-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
